@@ rtl/core/rfr_pkg.sv @@
package rfr_pkg;

    localparam int MAX_PEERS   = 16;
    localparam int PEER_IDX_W  = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int SLOT_W      = 4;
    localparam int ID_W        = 128;
    localparam int SRC_BYTES   = ID_W / 8;
    localparam int BURST_W     = $clog2(SRC_BYTES);
    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // operation codes
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // configuration register indexes
    localparam logic CFG_SRC_HIGH = 1'b0;
    localparam logic CFG_SRC_LOW  = 1'b1;

    // header byte counter marks
    localparam logic [4:0] HDR_TARGET_END = 5'd15;
    localparam logic [4:0] HDR_LEN0       = 5'd16;
    localparam logic [4:0] HDR_LEN1       = 5'd17;
    localparam logic [4:0] HDR_LEN2       = 5'd18;
    localparam logic [4:0] HDR_LEN3       = 5'd19;

    typedef enum logic [2:0] {
        ST_FWD       = 3'd0,
        ST_DROP      = 3'd1,
        ST_ADDED     = 3'd2,
        ST_FULL      = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    // one queue entry: a single result, or a request to send the source id
    typedef struct packed {
        logic              is_burst;
        status_t           status;
        logic [7:0]        data;
        logic              last;
        logic [SLOT_W-1:0] slot;
    } rfr_cmd_t;

endpackage

@@ rtl/core/rfr_front.sv @@
module rfr_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       operation,
    input  logic [7:0]       data_byte,
    input  logic [63:0]      peer_id_high,
    input  logic [63:0]      peer_id_low,
    input  logic             q_full,
    output logic             push,
    output rfr_pkg::rfr_cmd_t push_cmd
);
    import rfr_pkg::*;

    typedef enum logic [1:0] {
        PH_TARGET,
        PH_LENGTH,
        PH_DATA
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [4:0]        hdr_count_reg, hdr_count_next;
    logic [ID_W-1:0]   target_reg, target_next;
    logic [14:0]       first_word_reg, first_word_next;
    logic [30:0]       remaining_reg, remaining_next;
    logic              route_known_reg, route_known_next;
    logic [SLOT_W-1:0] route_slot_reg, route_slot_next;

    logic [ID_W-1:0]      peer_key_reg [MAX_PEERS];
    logic [MAX_PEERS-1:0] peer_valid_reg, peer_valid_next;

    logic                  accept;
    logic [ID_W-1:0]       target_shift;
    logic [ID_W-1:0]       lookup_key;
    logic [MAX_PEERS-1:0]  hit_vec;
    logic                  hit_found;
    logic [PEER_IDX_W-1:0] hit_idx;
    logic                  free_found;
    logic [PEER_IDX_W-1:0] free_idx;
    logic                  tbl_we;
    logic [15:0]           word;
    logic [30:0]           len_long;
    logic [30:0]           remaining_dec;

    assign in_ready      = !q_full;
    assign accept        = in_valid && in_ready;
    assign target_shift  = {target_reg[ID_W-9:0], data_byte};
    assign lookup_key    = (operation == OP_BYTE) ? target_shift : {peer_id_high, peer_id_low};
    assign word          = {first_word_reg[7:0], data_byte};
    assign len_long      = {first_word_reg, remaining_reg[7:0], data_byte};
    assign remaining_dec = remaining_reg - 31'd1;

    // parallel compare against every slot, lowest slot wins
    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < MAX_PEERS; i++)
        begin
            hit_vec[i] = peer_valid_reg[i] && (peer_key_reg[i] == lookup_key);
        end
        for (int i = MAX_PEERS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_found = 1'b1;
                hit_idx   = PEER_IDX_W'(i);
            end
            if (!peer_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = PEER_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        logic        pass_en;
        logic        pass_last;
        logic        fin;
        logic [30:0] fin_len;

        phase_next       = phase_reg;
        hdr_count_next   = hdr_count_reg;
        target_next      = target_reg;
        first_word_next  = first_word_reg;
        remaining_next   = remaining_reg;
        route_known_next = route_known_reg;
        route_slot_next  = route_slot_reg;
        peer_valid_next  = peer_valid_reg;
        tbl_we           = 1'b0;
        push             = 1'b0;
        push_cmd         = '0;
        pass_en          = 1'b0;
        pass_last        = 1'b0;
        fin              = 1'b0;
        fin_len          = '0;

        if (accept)
        begin
            unique case (operation)
                OP_BYTE:
                begin
                    unique case (phase_reg)
                        PH_TARGET:
                        begin
                            target_next    = target_shift;
                            hdr_count_next = hdr_count_reg + 5'd1;
                            if (hdr_count_reg == HDR_TARGET_END)
                            begin
                                push           = 1'b1;
                                phase_next     = PH_LENGTH;
                                hdr_count_next = HDR_LEN0;
                                if (hit_found)
                                begin
                                    route_known_next  = 1'b1;
                                    route_slot_next   = SLOT_W'(hit_idx);
                                    push_cmd.is_burst = 1'b1;
                                    push_cmd.status   = ST_FWD;
                                    push_cmd.slot     = SLOT_W'(hit_idx);
                                end
                                else
                                begin
                                    route_known_next = 1'b0;
                                    route_slot_next  = '0;
                                    push_cmd.status  = ST_DROP;
                                end
                            end
                        end
                        PH_LENGTH:
                        begin
                            priority if (hdr_count_reg == HDR_LEN0)
                            begin
                                first_word_next = {7'd0, data_byte};
                                pass_en         = 1'b1;
                                hdr_count_next  = HDR_LEN1;
                            end
                            else if (hdr_count_reg == HDR_LEN1)
                            begin
                                first_word_next = word[14:0];
                                if (word[15])
                                begin
                                    pass_en        = 1'b1;
                                    hdr_count_next = HDR_LEN2;
                                end
                                else
                                begin
                                    fin     = 1'b1;
                                    fin_len = {16'd0, word[14:0]};
                                end
                            end
                            else if (hdr_count_reg == HDR_LEN2)
                            begin
                                remaining_next = {23'd0, data_byte};
                                pass_en        = 1'b1;
                                hdr_count_next = HDR_LEN3;
                            end
                            else
                            begin
                                fin     = 1'b1;
                                fin_len = len_long;
                            end
                        end
                        PH_DATA:
                        begin
                            pass_en = 1'b1;
                            if (remaining_reg != 31'd0)
                            begin
                                remaining_next = remaining_dec;
                            end
                            if (remaining_reg <= 31'd1)
                            begin
                                pass_last      = 1'b1;
                                phase_next     = PH_TARGET;
                                hdr_count_next = '0;
                                remaining_next = '0;
                            end
                        end
                        default:
                        begin
                            phase_next     = PH_TARGET;
                            hdr_count_next = '0;
                            remaining_next = '0;
                        end
                    endcase

                    // length complete: zero length ends the frame here
                    if (fin)
                    begin
                        pass_en = 1'b1;
                        if (fin_len == 31'd0)
                        begin
                            pass_last      = 1'b1;
                            phase_next     = PH_TARGET;
                            hdr_count_next = '0;
                            remaining_next = '0;
                        end
                        else
                        begin
                            remaining_next = fin_len;
                            phase_next     = PH_DATA;
                        end
                    end

                    if (pass_en && route_known_reg)
                    begin
                        push          = 1'b1;
                        push_cmd.status = ST_FWD;
                        push_cmd.data = data_byte;
                        push_cmd.last = pass_last;
                        push_cmd.slot = route_slot_reg;
                    end
                end
                OP_ADD:
                begin
                    push = 1'b1;
                    if (hit_found)
                    begin
                        push_cmd.status = ST_ADDED;
                        push_cmd.slot   = SLOT_W'(hit_idx);
                    end
                    else if (free_found)
                    begin
                        tbl_we                    = 1'b1;
                        peer_valid_next[free_idx] = 1'b1;
                        push_cmd.status           = ST_ADDED;
                        push_cmd.slot             = SLOT_W'(free_idx);
                    end
                    else
                    begin
                        push_cmd.status = ST_FULL;
                    end
                end
                OP_REMOVE:
                begin
                    push = 1'b1;
                    if (hit_found)
                    begin
                        peer_valid_next[hit_idx] = 1'b0;
                        push_cmd.status          = ST_REMOVED;
                        push_cmd.slot            = SLOT_W'(hit_idx);
                    end
                    else
                    begin
                        push_cmd.status = ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    // unused operation code: no result
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TARGET;
            hdr_count_reg   <= '0;
            route_known_reg <= 1'b0;
            route_slot_reg  <= '0;
            peer_valid_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            hdr_count_reg   <= hdr_count_next;
            route_known_reg <= route_known_next;
            route_slot_reg  <= route_slot_next;
            peer_valid_reg  <= peer_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        first_word_reg <= first_word_next;
        remaining_reg  <= remaining_next;
        if (tbl_we)
        begin
            peer_key_reg[free_idx] <= {peer_id_high, peer_id_low};
        end
    end

endmodule

@@ rtl/core/rfr_queue.sv @@
module rfr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rfr_pkg::rfr_cmd_t push_cmd,
    input  logic              pop,
    output rfr_pkg::rfr_cmd_t head,
    output logic              full,
    output logic              empty
);
    import rfr_pkg::*;

    rfr_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/rfr_back.sv @@
module rfr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  rfr_pkg::rfr_cmd_t             q_head,
    output logic                          q_pop,
    input  logic [rfr_pkg::ID_W-1:0]      source_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [7:0]                    out_byte,
    output logic                          last,
    output logic [rfr_pkg::SLOT_W-1:0]    peer_slot
);
    import rfr_pkg::*;

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               last_reg, last_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               burst_active_reg, burst_active_next;
    logic [BURST_W-1:0] burst_idx_reg, burst_idx_next;
    logic [SLOT_W-1:0]  burst_slot_reg, burst_slot_next;

    logic [7:0] src_bytes [SRC_BYTES];
    logic       load;

    // source id goes out most significant byte first
    always_comb
    begin
        for (int i = 0; i < SRC_BYTES; i++)
        begin
            src_bytes[i] = source_id[ID_W-1-8*i -: 8];
        end
    end

    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        out_byte_next     = out_byte_reg;
        last_next         = last_reg;
        slot_next         = slot_reg;
        burst_active_next = burst_active_reg;
        burst_idx_next    = burst_idx_reg;
        burst_slot_next   = burst_slot_reg;
        q_pop             = 1'b0;

        if (load)
        begin
            out_valid_next = 1'b0;
            if (burst_active_reg)
            begin
                out_valid_next = 1'b1;
                status_next    = ST_FWD;
                out_byte_next  = src_bytes[burst_idx_reg];
                last_next      = 1'b0;
                slot_next      = burst_slot_reg;
                burst_idx_next = burst_idx_reg + 1'b1;
                if (burst_idx_reg == BURST_W'(SRC_BYTES - 1))
                begin
                    burst_active_next = 1'b0;
                end
            end
            else if (!q_empty)
            begin
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                status_next    = q_head.status;
                last_next      = q_head.last;
                slot_next      = q_head.slot;
                if (q_head.is_burst)
                begin
                    out_byte_next     = src_bytes[0];
                    burst_active_next = 1'b1;
                    burst_idx_next    = BURST_W'(1);
                    burst_slot_next   = q_head.slot;
                end
                else
                begin
                    out_byte_next = q_head.data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            burst_active_reg <= 1'b0;
            burst_idx_reg    <= '0;
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            burst_active_reg <= burst_active_next;
            burst_idx_reg    <= burst_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        out_byte_reg   <= out_byte_next;
        last_reg       <= last_next;
        slot_reg       <= slot_next;
        burst_slot_reg <= burst_slot_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign peer_slot = slot_reg;

endmodule

@@ rtl/core/relay_frame_router.sv @@
// relay frame router
// input channel (in_valid/in_ready): one transaction per stream byte (operation 0)
// or per peer table command (1 register, 2 remove). frames are a 16-byte target id,
// a 2- or 4-byte big-endian length, then data.
// output channel (out_valid/out_ready): forwarded bytes with last on the final byte,
// one drop result per unknown target, one result per table command.
// config channel (cfg_valid/cfg_ready, always ready): index 0 high, 1 low half of
// the source id; write only while the block is idle.
// the front parses and looks up the peer table one transaction per cycle while the
// queue has room; a 32-entry queue feeds the back, which expands a known target into
// 16 source id bytes and holds each result in an output register.
// a result is written into the queue when its transaction is accepted, then loaded
// into the output register. throughput: one input transaction and one result per
// cycle while in_ready and out_ready are high; length and data bytes queue behind the
// 16-byte source id burst, and the backlog drains while the target bytes of the next
// frame stream in. a stalled receiver fills the queue, after which in_ready drops.
// reset empties the queue, clears the peer table and restarts parsing at a target id.
module relay_frame_router (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic [63:0] peer_id_high,
    input  logic [63:0] peer_id_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [3:0]  peer_slot,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import rfr_pkg::*;

    logic [63:0] source_id_high_reg, source_id_low_reg;
    logic        push, q_full, q_empty, q_pop;
    rfr_cmd_t    push_cmd, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_id_high_reg <= '0;
            source_id_low_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SRC_HIGH: source_id_high_reg <= cfg_data;
                CFG_SRC_LOW:  source_id_low_reg  <= cfg_data;
                default:      source_id_low_reg  <= source_id_low_reg;
            endcase
        end
    end

    rfr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .data_byte    (data_byte),
        .peer_id_high (peer_id_high),
        .peer_id_low  (peer_id_low),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    rfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    rfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .source_id ({source_id_high_reg, source_id_low_reg}),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_byte  (out_byte),
        .last      (last),
        .peer_slot (peer_slot)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("queue push while full");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_NOT_FOUND))
        else $error("status code out of range");

    a_non_fwd_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_FWD)) |-> ((out_byte == 8'd0) && !last))
        else $error("non-forward result carries byte or last");

    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_DROP || status == ST_FULL || status == ST_NOT_FOUND))
        |-> (peer_slot == 4'd0))
        else $error("slot set on result that has none");
`endif

endmodule

@@ tb/sv/tb_relay_frame_router.sv @@
`timescale 1ns / 100ps

module tb_relay_frame_router;

    import rfr_pkg::*;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int POOL_SIZE   = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 6;

    typedef enum logic [1:0] {
        AT_TARGET,
        AT_LENGTH,
        AT_DATA
    } parse_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  data;
        logic        last;
        logic [3:0]  slot;
    } result_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  b;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        typed;
        logic        yields;
        result_t     want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = OP_BYTE;
    logic [7:0]  data_byte = 8'h00;
    logic [63:0] peer_id_high = 64'h0;
    logic [63:0] peer_id_low = 64'h0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic        last;
    logic [3:0]  peer_slot;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_SRC_HIGH;
    logic [63:0] cfg_data = 64'h0;

    relay_frame_router dut (.*);

    // routing model state
    logic [63:0] tbl_hi [MAX_PEERS];
    logic [63:0] tbl_lo [MAX_PEERS];
    logic        tbl_used [MAX_PEERS];
    parse_t      parse_at;
    logic [4:0]  hdr_cnt;
    logic [14:0] first_word;
    logic [30:0] len_left;
    logic [63:0] tgt_hi, tgt_lo;
    logic        fwd_known;
    logic [3:0]  fwd_slot;
    logic [63:0] own_hi, own_lo;

    result_t     step_results [$];
    result_t     pending_results [$];
    result_t     seen_want;
    stim_row_t   directed [$];
    logic [63:0] pool_hi [POOL_SIZE];
    logic [63:0] pool_lo [POOL_SIZE];

    int mismatches = 0;
    int random_items = 0;
    int burst_left = 0;
    bit sender_gaps = 1'b1;
    int holds_asked = 0;
    int holds_done = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #7_200_000;
        $display("tb_relay_frame_router NOT OK");
        $finish;
    end

    function automatic void push_result(input status_t st, input logic [7:0] b,
                                        input logic lst, input logic [3:0] slot);
        result_t r;
        r.status = st;
        r.data = b;
        r.last = lst;
        r.slot = slot;
        step_results.push_back(r);
    endfunction

    function automatic int lookup_peer(input logic [63:0] hi, input logic [63:0] lo);
        for (int i = 0; i < MAX_PEERS; i++)
            if (tbl_used[i] && tbl_hi[i] == hi && tbl_lo[i] == lo)
                return i;
        return -1;
    endfunction

    function automatic void forward(input logic [7:0] b, input logic lst);
        if (fwd_known)
            push_result(ST_FWD, b, lst, fwd_slot);
    endfunction

    function automatic void end_frame();
        parse_at = AT_TARGET;
        hdr_cnt = 5'd0;
        tgt_hi = 64'h0;
        tgt_lo = 64'h0;
        len_left = 31'd0;
    endfunction

    function automatic void close_length(input logic [7:0] b, input logic [31:0] len);
        if (len == 32'd0) begin
            forward(b, 1'b1);
            end_frame();
        end else begin
            forward(b, 1'b0);
            len_left = len[30:0];
            parse_at = AT_DATA;
        end
    endfunction

    function automatic void route_step(input logic [1:0] op, input logic [7:0] b,
                                       input logic [63:0] hi, input logic [63:0] lo);
        int s;
        logic [15:0]  w;
        logic [127:0] own;
        own = {own_hi, own_lo};
        if (op == OP_BYTE) begin
            case (parse_at)
                AT_TARGET: begin
                    if (hdr_cnt < 5'd8)
                        tgt_hi = {tgt_hi[55:0], b};
                    else
                        tgt_lo = {tgt_lo[55:0], b};
                    hdr_cnt = hdr_cnt + 5'd1;
                    if (hdr_cnt == HDR_LEN0) begin
                        s = lookup_peer(tgt_hi, tgt_lo);
                        if (s >= 0) begin
                            fwd_known = 1'b1;
                            fwd_slot = s[3:0];
                            for (int i = 0; i < 16; i++)
                                push_result(ST_FWD, own[127-8*i -: 8], 1'b0, fwd_slot);
                        end else begin
                            fwd_known = 1'b0;
                            fwd_slot = 4'd0;
                            push_result(ST_DROP, 8'h00, 1'b0, 4'd0);
                        end
                        parse_at = AT_LENGTH;
                    end
                end
                AT_LENGTH: begin
                    if (hdr_cnt == HDR_LEN0) begin
                        first_word = {7'd0, b};
                        forward(b, 1'b0);
                        hdr_cnt = HDR_LEN1;
                    end else if (hdr_cnt == HDR_LEN1) begin
                        w = {first_word[7:0], b};
                        first_word = w[14:0];
                        if (w[15]) begin
                            forward(b, 1'b0);
                            hdr_cnt = HDR_LEN2;
                        end else begin
                            close_length(b, {16'd0, w});
                        end
                    end else if (hdr_cnt == HDR_LEN2) begin
                        len_left = {23'd0, b};
                        forward(b, 1'b0);
                        hdr_cnt = HDR_LEN3;
                    end else begin
                        close_length(b, {1'b0, first_word, len_left[7:0], b});
                    end
                end
                AT_DATA: begin
                    if (len_left != 31'd0)
                        len_left = len_left - 31'd1;
                    forward(b, len_left == 31'd0);
                    if (len_left == 31'd0)
                        end_frame();
                end
                default: end_frame();
            endcase
        end else if (op == OP_ADD) begin
            s = lookup_peer(hi, lo);
            if (s >= 0) begin
                push_result(ST_ADDED, 8'h00, 1'b0, s[3:0]);
            end else begin
                for (int i = 0; i < MAX_PEERS; i++) begin
                    if (s < 0 && !tbl_used[i]) begin
                        tbl_used[i] = 1'b1;
                        tbl_hi[i] = hi;
                        tbl_lo[i] = lo;
                        s = i;
                    end
                end
                if (s >= 0)
                    push_result(ST_ADDED, 8'h00, 1'b0, s[3:0]);
                else
                    push_result(ST_FULL, 8'h00, 1'b0, 4'd0);
            end
        end else if (op == OP_REMOVE) begin
            s = lookup_peer(hi, lo);
            if (s >= 0) begin
                tbl_used[s] = 1'b0;
                push_result(ST_REMOVED, 8'h00, 1'b0, s[3:0]);
            end else begin
                push_result(ST_NOT_FOUND, 8'h00, 1'b0, 4'd0);
            end
        end
    endfunction

    function automatic stim_row_t mk_row(input logic [1:0] op, input logic [7:0] b,
                                         input logic [63:0] hi, input logic [63:0] lo,
                                         input logic typed, input logic yields,
                                         input status_t st, input logic [3:0] slot);
        stim_row_t r;
        r.op = op;
        r.b = b;
        r.hi = hi;
        r.lo = lo;
        r.typed = typed;
        r.yields = yields;
        r.want.status = st;
        r.want.data = 8'h00;
        r.want.last = 1'b0;
        r.want.slot = slot;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < 10)
            $display("%s", msg);
        mismatches++;
    endtask

    task automatic drive_item(input stim_row_t r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_gaps ? $urandom_range(1, 7) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= r.op;
        data_byte <= r.b;
        peer_id_high <= r.hi;
        peer_id_low <= r.lo;
        do @(posedge clk); while (!in_ready);
        step_results.delete();
        route_step(r.op, r.b, r.hi, r.lo);
        if (r.typed) begin
            if (r.yields)
                pending_results.push_back(r.want);
        end else begin
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic send(input logic [1:0] op, input logic [7:0] b,
                        input logic [63:0] hi, input logic [63:0] lo);
        drive_item(mk_row(op, b, hi, lo, 1'b0, 1'b0, ST_FWD, 4'd0));
        if (op != OP_IGNORED)
            random_items++;
    endtask

    // wait out every pending result, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic program_source(input logic [63:0] hi, input logic [63:0] lo);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SRC_HIGH;
        cfg_data <= hi;
        do @(posedge clk); while (!cfg_ready);
        own_hi = hi;
        cfg_index <= CFG_SRC_LOW;
        cfg_data <= lo;
        do @(posedge clk); while (!cfg_ready);
        own_lo = lo;
        cfg_valid <= 1'b0;
    endtask

    task automatic table_op(input logic [63:0] cur_hi, input logic [63:0] cur_lo);
        int k;
        int sel;
        k = $urandom_range(0, POOL_SIZE - 1);
        sel = $urandom_range(0, 9);
        if (sel < 5)
            send(OP_ADD, 8'($urandom), pool_hi[k], pool_lo[k]);
        else if (sel < 8)
            send(OP_REMOVE, 8'($urandom), pool_hi[k], pool_lo[k]);
        else if (sel == 8)
            send(OP_IGNORED, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
        else
            // pulls the route out from under a frame in flight
            send(OP_REMOVE, 8'($urandom), cur_hi, cur_lo);
    endtask

    task automatic send_frame();
        int used [$];
        int pick;
        int mode;
        logic [31:0]  len;
        logic [127:0] id;
        logic [7:0]   bytes [$];
        for (int i = 0; i < MAX_PEERS; i++)
            if (tbl_used[i])
                used.push_back(i);
        if (used.size() > 0 && $urandom_range(0, 3) != 0) begin
            pick = used[$urandom_range(0, used.size() - 1)];
            id = {tbl_hi[pick], tbl_lo[pick]};
        end else if ($urandom_range(0, 1) == 1) begin
            pick = $urandom_range(0, POOL_SIZE - 1);
            id = {pool_hi[pick], pool_lo[pick]};
        end else begin
            id = {$urandom, $urandom, $urandom, $urandom};
        end
        for (int i = 0; i < 16; i++)
            bytes.push_back(id[127-8*i -: 8]);
        mode = $urandom_range(0, 19);
        if (mode < 13) begin
            if (mode < 3)
                len = 32'd0;
            else if (mode < 11)
                len = $urandom_range(1, 6);
            else
                len = $urandom_range(7, 30);
            bytes.push_back({1'b0, len[14:8]});
            bytes.push_back(len[7:0]);
        end else begin
            len = $urandom_range(0, 8);
            bytes.push_back({1'b1, len[30:24]});
            bytes.push_back(len[23:16]);
            bytes.push_back(len[15:8]);
            bytes.push_back(len[7:0]);
        end
        for (int i = 0; i < len; i++)
            bytes.push_back(8'($urandom));
        foreach (bytes[i]) begin
            if ($urandom_range(0, 15) == 0)
                table_op(id[127:64], id[63:0]);
            send(OP_BYTE, bytes[i], {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    // receiver: rolling stall pattern, plus long hold-offs on request
    initial begin
        logic [7:0] ready_mask;
        int tick;
        ready_mask = 8'hFF;
        tick = 0;
        forever begin
            @(posedge clk);
            if (holds_asked != holds_done) begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                if (tick % 32 == 0)
                    ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
                out_ready <= ready_mask[tick % 8];
                tick++;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected transaction: status %0d byte %02h last %0d slot %0d",
                                        status, out_byte, last, peer_slot));
            end else begin
                seen_want = pending_results.pop_front();
                if (status !== seen_want.status || out_byte !== seen_want.data ||
                    last !== seen_want.last || peer_slot !== seen_want.slot)
                    flag_mismatch($sformatf(
                        "mismatch: want status %0d byte %02h last %0d slot %0d, got %0d %02h %0d %0d",
                        seen_want.status, seen_want.data, seen_want.last, seen_want.slot,
                        status, out_byte, last, peer_slot));
            end
        end
    end

    initial begin
        bit paused;
        paused = 1'b0;
        for (int i = 0; i < MAX_PEERS; i++)
            tbl_used[i] = 1'b0;
        own_hi = 64'h0;
        own_lo = 64'h0;
        first_word = 15'd0;
        fwd_known = 1'b0;
        fwd_slot = 4'd0;
        end_frame();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        pool_hi[1] = 64'h0;
        pool_lo[1] = 64'h1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_source(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);

        directed.push_back(mk_row(OP_REMOVE, 8'h00, '1, '1, 1'b1, 1'b1, ST_NOT_FOUND, 4'd0));
        directed.push_back(mk_row(OP_ADD, 8'h00, '1, '1, 1'b1, 1'b1, ST_ADDED, 4'd0));
        directed.push_back(mk_row(OP_ADD, 8'h00, '1, '1, 1'b1, 1'b1, ST_ADDED, 4'd0));
        directed.push_back(mk_row(OP_ADD, 8'hFF, '0, '0, 1'b1, 1'b1, ST_ADDED, 4'd1));
        directed.push_back(mk_row(OP_IGNORED, 8'hA5, '1, '1, 1'b1, 1'b0, ST_FWD, 4'd0));
        // frame to the all-ones peer with a zero length
        for (int i = 0; i < 16; i++)
            directed.push_back(mk_row(OP_BYTE, 8'hFF, '0, '0, 1'b0, 1'b0, ST_FWD, 4'd0));
        directed.push_back(mk_row(OP_BYTE, 8'h00, '0, '0, 1'b0, 1'b0, ST_FWD, 4'd0));
        directed.push_back(mk_row(OP_BYTE, 8'h00, '0, '0, 1'b0, 1'b0, ST_FWD, 4'd0));
        directed.push_back(mk_row(OP_REMOVE, 8'h00, '1, '1, 1'b1, 1'b1, ST_REMOVED, 4'd0));
        foreach (directed[i])
            drive_item(directed[i]);
        settle();

        for (int p = 0; p < 4; p++) begin
            if (p == 0)
                program_source(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
            else
                program_source({$urandom, $urandom}, {$urandom, $urandom});
            sender_gaps = (p != 3);
            if (p == 2)
                holds_asked++;
            while (random_items < (p + 1) * 105) begin
                repeat ($urandom_range(0, 3))
                    table_op(64'h0, 64'h0);
                send_frame();
                if (p == 1 && !paused && random_items >= 160) begin
                    settle();
                    paused = 1'b1;
                end
            end
            settle();
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_relay_frame_router OK");
        else
            $display("tb_relay_frame_router NOT OK");
        $finish;
    end

endmodule

@@ relay_frame_router.f @@
rtl/core/rfr_pkg.sv
rtl/core/rfr_front.sv
rtl/core/rfr_queue.sv
rtl/core/rfr_back.sv
rtl/core/relay_frame_router.sv
tb/sv/tb_relay_frame_router.sv
